>>> rtl/core/deterministic_miller_rabin_64_unit_defines.svh
// Assertion macros for the Miller-Rabin unit
`ifndef DETERMINISTIC_MILLER_RABIN_64_UNIT_DEFINES_SVH
`define DETERMINISTIC_MILLER_RABIN_64_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define DMR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define DMR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DMR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define DMR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/core/dmr64_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmr64_pkg
// Shared types and constants of the Miller-Rabin unit.
// ----------------------------------------------------------------------------
package dmr64_pkg;

    localparam int TABLE_SIZE = 12;
    localparam int PRIME_W    = 6;

    typedef logic [PRIME_W-1:0] prime_t;

    function automatic prime_t prime_at(input logic [3:0] idx);
        prime_t p;
        case (idx)
            4'd0:    p = 6'd2;
            4'd1:    p = 6'd3;
            4'd2:    p = 6'd5;
            4'd3:    p = 6'd7;
            4'd4:    p = 6'd11;
            4'd5:    p = 6'd13;
            4'd6:    p = 6'd17;
            4'd7:    p = 6'd19;
            4'd8:    p = 6'd23;
            4'd9:    p = 6'd29;
            4'd10:   p = 6'd31;
            4'd11:   p = 6'd37;
            default: p = 6'd2;
        endcase
        return p;
    endfunction

    // one-hot sequencer states
    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_TRIAL  = 13'b0000000000010,
        ST_SPLIT  = 13'b0000000000100,
        ST_BASE   = 13'b0000000001000,
        ST_EXPBIT = 13'b0000000010000,
        ST_MULMUL = 13'b0000000100000,
        ST_MULSQ  = 13'b0000001000000,
        ST_CHECK  = 13'b0000010000000,
        ST_CHAIN  = 13'b0000100000000,
        ST_CHMUL  = 13'b0001000000000,
        ST_CHCHK  = 13'b0010000000000,
        ST_DONE   = 13'b0100000000000,
        ST_MODLOOP= 13'b1000000000000
    } state_t;

    // modmul unit control
    typedef struct packed {
        logic start;
        logic busy;
    } mm_ctrl_t;

endpackage

>>> rtl/core/deterministic_miller_rabin_64_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deterministic_miller_rabin_64_unit
// Deterministic Miller-Rabin primality test over a bit-serial mod multiplier.
// ----------------------------------------------------------------------------
// Trial division takes one remainder bit a cycle over the 12 table primes;
// each multiply runs in the shared mod multiplier, and an exponent bit costs
// up to two multiplies.
// One word at a time; a new candidate is taken once the result has left.
// rst_n clears the sequencer and the output valid asynchronously.
module deterministic_miller_rabin_64_unit #(
    parameter int NUM_BITS  = 64,
    parameter int NUM_BASES = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] candidate,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        is_prime
);
    import dmr64_pkg::*;

    `include "deterministic_miller_rabin_64_unit_defines.svh"

    localparam int CW    = $clog2(NUM_BITS + 1);
    localparam int NB    = (NUM_BASES > TABLE_SIZE) ? TABLE_SIZE :
                           ((NUM_BASES < 1) ? 1 : NUM_BASES);
    localparam int SW    = $clog2(NUM_BITS);

    state_t              state_reg, state_next;
    logic [NUM_BITS-1:0] n_reg, n_next;
    logic [NUM_BITS-1:0] d_reg, d_next;
    logic [NUM_BITS-1:0] x_reg, x_next;
    logic [NUM_BITS-1:0] sq_reg, sq_next;
    logic [SW-1:0]       s_reg, s_next;
    logic [SW-1:0]       r_reg, r_next;
    logic [3:0]          idx_reg, idx_next;
    logic [CW-1:0]       bit_reg, bit_next;
    logic [PRIME_W-1:0]  rem_reg, rem_next;
    logic                res_reg, res_next;
    logic                ov_reg, ov_next;

    logic                mm_start;
    logic [NUM_BITS-1:0] mm_a, mm_b;
    logic [NUM_BITS-1:0] mm_res;
    mm_ctrl_t            mm_ctrl;

    logic [NUM_BITS-1:0] nm1;
    prime_t              p;
    logic [PRIME_W:0]    rem2;

    assign nm1  = n_reg - 1'b1;
    assign p    = prime_at(idx_reg);
    assign rem2 = {rem_reg, n_reg[bit_reg[SW-1:0]]};

    dmr64_mulmod #(.NUM_BITS(NUM_BITS)) u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mm_start),
        .a      (mm_a),
        .b      (mm_b),
        .m      (n_reg),
        .ctrl   (mm_ctrl),
        .result (mm_res)
    );

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        x_next     = x_reg;
        sq_next    = sq_reg;
        s_next     = s_reg;
        r_next     = r_reg;
        idx_next   = idx_reg;
        bit_next   = bit_reg;
        rem_next   = rem_reg;
        res_next   = res_reg;
        ov_next    = ov_reg;
        mm_start   = 1'b0;
        mm_a       = x_reg;
        mm_b       = sq_reg;
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !ov_reg)
                begin
                    n_next     = candidate[NUM_BITS-1:0];
                    idx_next   = '0;
                    bit_next   = CW'(NUM_BITS - 1);
                    rem_next   = '0;
                    state_next = ST_TRIAL;
                end
            end
            ST_TRIAL:
            begin
                // restoring remainder, one dividend bit a cycle
                if (rem2 >= {1'b0, p})
                    rem_next = PRIME_W'(rem2 - {1'b0, p});
                else
                    rem_next = PRIME_W'(rem2);
                if (bit_reg == '0)
                begin
                    bit_next = CW'(NUM_BITS - 1);
                    rem_next = '0;
                    if (n_reg < NUM_BITS'(2))
                    begin
                        res_next   = 1'b0;
                        state_next = ST_DONE;
                    end
                    else if (((rem2 >= {1'b0, p}) ? PRIME_W'(rem2 - {1'b0, p})
                                                 : PRIME_W'(rem2)) == '0)
                    begin
                        res_next   = (n_reg == NUM_BITS'(p));
                        state_next = ST_DONE;
                    end
                    else if (idx_reg == 4'(TABLE_SIZE - 1))
                    begin
                        d_next     = nm1;
                        s_next     = '0;
                        idx_next   = '0;
                        state_next = ST_SPLIT;
                    end
                    else
                        idx_next = idx_reg + 1'b1;
                end
                else
                    bit_next = bit_reg - 1'b1;
            end
            ST_SPLIT:
            begin
                if (d_reg[0])
                    state_next = ST_BASE;
                else
                begin
                    d_next = d_reg >> 1;
                    s_next = s_reg + 1'b1;
                end
            end
            ST_BASE:
            begin
                x_next     = NUM_BITS'(1);
                sq_next    = NUM_BITS'(p);
                bit_next   = '0;
                state_next = ST_EXPBIT;
            end
            ST_EXPBIT:
            begin
                // right-to-left binary exponent, one bit per step
                if (bit_reg == CW'(NUM_BITS) || (d_reg >> bit_reg) == '0)
                    state_next = ST_CHECK;
                else if (d_reg[bit_reg[SW-1:0]])
                begin
                    mm_start   = 1'b1;
                    state_next = ST_MULMUL;
                end
                else
                begin
                    mm_start   = 1'b1;
                    mm_a       = sq_reg;
                    state_next = ST_MULSQ;
                end
            end
            ST_MULMUL:
            begin
                if (!mm_ctrl.busy)
                begin
                    x_next     = mm_res;
                    mm_start   = 1'b1;
                    mm_a       = sq_reg;
                    state_next = ST_MULSQ;
                end
            end
            ST_MULSQ:
            begin
                mm_a = sq_reg;
                if (!mm_ctrl.busy)
                begin
                    sq_next    = mm_res;
                    bit_next   = bit_reg + 1'b1;
                    state_next = ST_EXPBIT;
                end
            end
            ST_CHECK:
            begin
                r_next = SW'(1);
                if (x_reg == NUM_BITS'(1) || x_reg == nm1)
                    state_next = ST_MODLOOP;
                else
                    state_next = ST_CHAIN;
            end
            ST_CHAIN:
            begin
                if (r_reg >= s_reg)
                begin
                    res_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    mm_start   = 1'b1;
                    mm_b       = x_reg;
                    state_next = ST_CHMUL;
                end
            end
            ST_CHMUL:
            begin
                mm_b = x_reg;
                if (!mm_ctrl.busy)
                begin
                    x_next     = mm_res;
                    state_next = ST_CHCHK;
                end
            end
            ST_CHCHK:
            begin
                r_next = r_reg + 1'b1;
                if (x_reg == nm1)
                    state_next = ST_MODLOOP;
                else
                    state_next = ST_CHAIN;
            end
            ST_MODLOOP:
            begin
                // base passed; advance or finish
                if (idx_reg == 4'(NB - 1))
                begin
                    res_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_BASE;
                end
            end
            ST_DONE:
            begin
                if (!ov_reg)
                begin
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        x_reg   <= x_next;
        sq_reg  <= sq_next;
        s_reg   <= s_next;
        r_reg   <= r_next;
        idx_reg <= idx_next;
        bit_reg <= bit_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    assign in_stall  = (state_reg != ST_IDLE) || ov_reg;
    assign out_valid = ov_reg;
    assign is_prime  = res_reg;

    `DMR_ASSERT_IMPL(a_no_take_busy, clk, rst_n, state_reg != ST_IDLE, in_stall,
        "input taken while busy")
    `DMR_ASSERT_NEXT(a_take_starts, clk, rst_n, in_valid && !in_stall,
        state_reg == ST_TRIAL, "accepted word did not start trial division")
    `DMR_ASSERT_IMPL(a_mm_idle_start, clk, rst_n, mm_start,
        !mm_ctrl.busy, "multiplier started while busy")
    `DMR_ASSERT_NEXT(a_done_out, clk, rst_n, state_reg == ST_DONE && !ov_reg,
        ov_reg, "result not presented")

endmodule

>>> rtl/core/dmr64_mulmod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmr64_mulmod
// Bit-serial modular multiply: one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module dmr64_mulmod #(
    parameter int NUM_BITS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [NUM_BITS-1:0]  a,
    input  logic [NUM_BITS-1:0]  b,
    input  logic [NUM_BITS-1:0]  m,
    output dmr64_pkg::mm_ctrl_t  ctrl,
    output logic [NUM_BITS-1:0]  result
);
    import dmr64_pkg::*;

    localparam int CW = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] acc_reg, acc_next;
    logic [NUM_BITS-1:0] b_reg, b_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic [NUM_BITS-1:0] dbl, room1, room2;

    always_comb
    begin
        // acc + acc mod m, then + a mod m when the multiplier bit is set
        room1 = m - acc_reg;
        dbl   = (acc_reg >= room1) ? (acc_reg - room1) : (acc_reg + acc_reg);
        room2 = m - a;
        acc_next  = acc_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            acc_next  = '0;
            b_next    = b;
            cnt_next  = CW'(NUM_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg[NUM_BITS-1])
                acc_next = (dbl >= room2) ? (dbl - room2) : (dbl + a);
            else
                acc_next = dbl;
            b_next   = {b_reg[NUM_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        b_reg   <= b_next;
    end

    assign ctrl.start = start;
    assign ctrl.busy  = busy_reg;
    assign result     = acc_reg;

endmodule
